/* rtl/imuqf_pkg.sv */
package imuqf_pkg;

    localparam int MUL_W = 36;
    localparam int UOP_W = 6;

    localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;
    localparam logic signed [63:0] QSAT = 64'sd4294967296;

    localparam logic REG_GAIN_BETA = 1'b0;
    localparam logic REG_TIME_STEP = 1'b1;

    typedef enum logic [UOP_W-1:0] {
        U_AXX, U_AYY, U_AZZ, U_ASQRT, U_DVX, U_DVY, U_DVZ,
        U_F1A, U_F1B, U_F2A, U_F2B, U_F3A, U_F3B,
        U_G0A, U_G0B, U_G1A, U_G1B, U_G1C, U_G2A, U_G2B, U_G2C, U_G3A, U_G3B,
        U_GS0, U_GS1, U_GS2, U_GS3, U_GSQRT, U_GN0, U_GN1, U_GN2, U_GN3,
        U_R0A, U_R0B, U_R0C, U_R0D, U_R0E,
        U_R1A, U_R1B, U_R1C, U_R1D, U_R1E,
        U_R2A, U_R2B, U_R2C, U_R2D, U_R2E,
        U_R3A, U_R3B, U_R3C, U_R3D, U_R3E,
        U_QS0, U_QS1, U_QS2, U_QS3, U_QSQRT, U_QD0, U_QD1, U_QD2, U_QD3,
        U_OUT
    } uop_t;

    typedef enum logic [1:0] {
        S_IDLE, S_RUN, S_WRITE, S_WAIT
    } ctrl_state_t;

    typedef struct packed {
        uop_t uop;
        logic accept;
        logic issue;
        logic write;
        logic start;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic unit_done;
        logic asum_zero;
        logic gs_zero;
        logic qs_zero;
        logic out_free;
    } status_t;

    function automatic logic signed [63:0] clamp(input logic signed [63:0] v,
                                                 input logic signed [63:0] lim);
        logic signed [63:0] r;
        r = v;
        if (v > lim)
            r = lim;
        else if (v < -lim)
            r = -lim;
        return r;
    endfunction

    function automatic logic uop_is_unit(input uop_t u);
        return u inside {U_ASQRT, U_DVX, U_DVY, U_DVZ, U_GSQRT, U_GN0, U_GN1, U_GN2,
                         U_GN3, U_QSQRT, U_QD0, U_QD1, U_QD2, U_QD3};
    endfunction

endpackage

/* rtl/imu_orientation_quaternion_filter.sv */
// Six-axis gradient-descent orientation filter. Each accepted sample (raw
// acceleration plus Q5.11 rad/s angular rate) updates the kept Q1.30 quaternion
// and returns it as one transaction. When the acceleration is all zero the
// correction term is skipped. The work is done by one shared 64-step radix-2
// divider used eleven times, a 32-step square-root unit used three times and
// 47 steps on one shared 36x36 multiplier. The sample port stalls while a
// sample is in work; a finished quaternion waits in its output register, so
// the next sample is taken while it is still unread. The user must write
// gain_beta and time_step only while the block is idle; the block itself does
// not enforce this.
module imu_orientation_quaternion_filter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               write_enable,
    input  logic               reg_index,
    input  logic [23:0]        write_data,
    input  logic               sample_valid,
    output logic               sample_stall,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] rate_x,
    input  logic signed [15:0] rate_y,
    input  logic signed [15:0] rate_z,
    output logic               quat_valid,
    input  logic               quat_stall,
    output logic signed [31:0] quat_w,
    output logic signed [31:0] quat_x,
    output logic signed [31:0] quat_y,
    output logic signed [31:0] quat_z
);
    import imuqf_pkg::*;

    cmd_t    cmd;
    status_t status;

    imuqf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .status       (status),
        .cmd          (cmd)
    );

    imuqf_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data),
        .accel_x      (accel_x),
        .accel_y      (accel_y),
        .accel_z      (accel_z),
        .rate_x       (rate_x),
        .rate_y       (rate_y),
        .rate_z       (rate_z),
        .quat_valid   (quat_valid),
        .quat_stall   (quat_stall),
        .quat_w       (quat_w),
        .quat_x       (quat_x),
        .quat_y       (quat_y),
        .quat_z       (quat_z)
    );
endmodule

/* rtl/imuqf_sqrt.sv */
module imuqf_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    import imuqf_pkg::*;

    logic [63:0] rad_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [4:0]  count_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        ge;

    assign rem_sh = {rem_reg, rad_reg[63:62]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign ge = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 5'd1;
                if (count_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg <= radicand;
            rem_reg <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[61:0], 2'b00};
            if (ge)
            begin
                rem_reg <= 34'(rem_sh - trial);
                root_reg <= {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[33:0];
                root_reg <= {root_reg[30:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

/* rtl/imuqf_div.sv */
module imuqf_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] dividend,
    input  logic [31:0]        divisor,
    output logic               done,
    output logic signed [63:0] quotient
);
    import imuqf_pkg::*;

    logic [63:0] mag_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvs_reg;
    logic        neg_reg;
    logic [5:0]  count_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] rem_sh;
    logic        ge;

    assign rem_sh = {rem_reg, mag_reg[63]};
    assign ge = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 6'd1;
                if (count_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[63];
            mag_reg <= dividend[63] ? 64'(-dividend) : 64'(dividend);
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            mag_reg <= {mag_reg[62:0], ge};
            rem_reg <= ge ? 32'(rem_sh - {1'b0, dvs_reg}) : rem_sh[31:0];
        end
    end

    assign done = done_reg;
    assign quotient = neg_reg ? -signed'(mag_reg) : signed'(mag_reg);
endmodule

/* rtl/imuqf_datapath.sv */
module imuqf_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  imuqf_pkg::cmd_t       cmd,
    output imuqf_pkg::status_t    status,
    input  logic                  write_enable,
    input  logic                  reg_index,
    input  logic [23:0]           write_data,
    input  logic signed [15:0]    accel_x,
    input  logic signed [15:0]    accel_y,
    input  logic signed [15:0]    accel_z,
    input  logic signed [15:0]    rate_x,
    input  logic signed [15:0]    rate_y,
    input  logic signed [15:0]    rate_z,
    output logic                  quat_valid,
    input  logic                  quat_stall,
    output logic signed [31:0]    quat_w,
    output logic signed [31:0]    quat_x,
    output logic signed [31:0]    quat_y,
    output logic signed [31:0]    quat_z
);
    import imuqf_pkg::*;

    logic [15:0] beta_reg;
    logic [23:0] ts_reg;
    logic signed [31:0] q_reg [4];
    logic signed [15:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg, gz_reg;
    logic signed [31:0] nx_reg, ny_reg, nz_reg;
    logic signed [MUL_W-1:0] f1_reg, f2_reg, f3_reg;
    logic signed [MUL_W-1:0] g_reg [4];
    logic signed [MUL_W-1:0] gn_reg [4];
    logic signed [33:0] nq_reg [4];
    logic signed [63:0] t_reg, acc_reg, racc_reg, prod_reg;
    logic signed [MUL_W-1:0] rr_reg;
    logic [63:0] asum_reg, gs_reg, qs_reg;
    logic signed [31:0] qo_reg [4];
    logic quat_valid_reg;

    logic signed [MUL_W-1:0] ma, mb;
    logic signed [71:0] full;
    logic signed [63:0] mq;
    logic signed [31:0] s [4];
    logic [63:0] radicand;
    logic signed [63:0] dividend;
    logic sqrt_done, div_done;
    logic [31:0] root;
    logic signed [63:0] quotient;
    logic out_free;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            s[i] = 32'(nq_reg[i] >>> 2);
    end

    assign out_free = !quat_valid_reg || !quat_stall;

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.uop)
            U_AXX: begin ma = 36'(ax_reg); mb = 36'(ax_reg); end
            U_AYY: begin ma = 36'(ay_reg); mb = 36'(ay_reg); end
            U_AZZ: begin ma = 36'(az_reg); mb = 36'(az_reg); end
            U_F1A: begin ma = 36'(q_reg[1]); mb = 36'(q_reg[3]); end
            U_F1B: begin ma = 36'(q_reg[0]); mb = 36'(q_reg[2]); end
            U_F2A: begin ma = 36'(q_reg[0]); mb = 36'(q_reg[1]); end
            U_F2B: begin ma = 36'(q_reg[2]); mb = 36'(q_reg[3]); end
            U_F3A: begin ma = 36'(q_reg[1]); mb = 36'(q_reg[1]); end
            U_F3B: begin ma = 36'(q_reg[2]); mb = 36'(q_reg[2]); end
            U_G0A: begin ma = 36'(q_reg[1]); mb = f2_reg; end
            U_G0B: begin ma = 36'(q_reg[2]); mb = f1_reg; end
            U_G1A: begin ma = 36'(q_reg[3]); mb = f1_reg; end
            U_G1B: begin ma = 36'(q_reg[0]); mb = f2_reg; end
            U_G1C: begin ma = 36'(q_reg[1]); mb = f3_reg; end
            U_G2A: begin ma = 36'(q_reg[3]); mb = f2_reg; end
            U_G2B: begin ma = 36'(q_reg[2]); mb = f3_reg; end
            U_G2C: begin ma = 36'(q_reg[0]); mb = f1_reg; end
            U_G3A: begin ma = 36'(q_reg[1]); mb = f1_reg; end
            U_G3B: begin ma = 36'(q_reg[2]); mb = f2_reg; end
            U_GS0: begin ma = g_reg[0]; mb = g_reg[0]; end
            U_GS1: begin ma = g_reg[1]; mb = g_reg[1]; end
            U_GS2: begin ma = g_reg[2]; mb = g_reg[2]; end
            U_GS3: begin ma = g_reg[3]; mb = g_reg[3]; end
            U_R0A: begin ma = 36'(q_reg[1]); mb = 36'(gx_reg); end
            U_R0B: begin ma = 36'(q_reg[2]); mb = 36'(gy_reg); end
            U_R0C: begin ma = 36'(q_reg[3]); mb = 36'(gz_reg); end
            U_R1A: begin ma = 36'(q_reg[0]); mb = 36'(gx_reg); end
            U_R1B: begin ma = 36'(q_reg[2]); mb = 36'(gz_reg); end
            U_R1C: begin ma = 36'(q_reg[3]); mb = 36'(gy_reg); end
            U_R2A: begin ma = 36'(q_reg[0]); mb = 36'(gy_reg); end
            U_R2B: begin ma = 36'(q_reg[1]); mb = 36'(gz_reg); end
            U_R2C: begin ma = 36'(q_reg[3]); mb = 36'(gx_reg); end
            U_R3A: begin ma = 36'(q_reg[0]); mb = 36'(gz_reg); end
            U_R3B: begin ma = 36'(q_reg[1]); mb = 36'(gy_reg); end
            U_R3C: begin ma = 36'(q_reg[2]); mb = 36'(gx_reg); end
            U_R0D: begin ma = 36'({1'b0, beta_reg}); mb = gn_reg[0]; end
            U_R1D: begin ma = 36'({1'b0, beta_reg}); mb = gn_reg[1]; end
            U_R2D: begin ma = 36'({1'b0, beta_reg}); mb = gn_reg[2]; end
            U_R3D: begin ma = 36'({1'b0, beta_reg}); mb = gn_reg[3]; end
            U_R0E, U_R1E, U_R2E, U_R3E:
            begin
                ma = rr_reg;
                mb = 36'({1'b0, ts_reg});
            end
            U_QS0: begin ma = 36'(s[0]); mb = 36'(s[0]); end
            U_QS1: begin ma = 36'(s[1]); mb = 36'(s[1]); end
            U_QS2: begin ma = 36'(s[2]); mb = 36'(s[2]); end
            U_QS3: begin ma = 36'(s[3]); mb = 36'(s[3]); end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    assign full = ma * mb;
    assign mq = prod_reg >>> 30;

    always_comb
    begin
        radicand = qs_reg;
        case (cmd.uop)
            U_ASQRT: radicand = {asum_reg[31:0], 32'd0};
            U_GSQRT: radicand = {gs_reg[59:0], 4'd0};
            default: radicand = qs_reg;
        endcase
    end

    always_comb
    begin
        dividend = '0;
        case (cmd.uop)
            U_DVX: dividend = 64'(ax_reg) <<< 46;
            U_DVY: dividend = 64'(ay_reg) <<< 46;
            U_DVZ: dividend = 64'(az_reg) <<< 46;
            U_GN0: dividend = 64'(g_reg[0]) <<< 32;
            U_GN1: dividend = 64'(g_reg[1]) <<< 32;
            U_GN2: dividend = 64'(g_reg[2]) <<< 32;
            U_GN3: dividend = 64'(g_reg[3]) <<< 32;
            U_QD0: dividend = 64'(nq_reg[0]) <<< 28;
            U_QD1: dividend = 64'(nq_reg[1]) <<< 28;
            U_QD2: dividend = 64'(nq_reg[2]) <<< 28;
            U_QD3: dividend = 64'(nq_reg[3]) <<< 28;
            default: dividend = '0;
        endcase
    end

    imuqf_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start && (cmd.uop == U_ASQRT || cmd.uop == U_GSQRT ||
                                 cmd.uop == U_QSQRT)),
        .radicand (radicand),
        .done     (sqrt_done),
        .root     (root)
    );

    imuqf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start && !(cmd.uop == U_ASQRT || cmd.uop == U_GSQRT ||
                                  cmd.uop == U_QSQRT)),
        .dividend (dividend),
        .divisor  (root),
        .done     (div_done),
        .quotient (quotient)
    );

    // config and kept orientation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta_reg <= 16'd1638;
            ts_reg <= 24'd16777;
            q_reg[0] <= 32'sd1073741824;
            q_reg[1] <= '0;
            q_reg[2] <= '0;
            q_reg[3] <= '0;
        end
        else
        begin
            if (write_enable)
            begin
                case (reg_index)
                    REG_GAIN_BETA: beta_reg <= write_data[15:0];
                    REG_TIME_STEP: ts_reg <= write_data;
                    default: ;
                endcase
            end
            if (div_done)
            begin
                case (cmd.uop)
                    U_QD0: q_reg[0] <= 32'(clamp(quotient, ONE_Q30));
                    U_QD1: q_reg[1] <= 32'(clamp(quotient, ONE_Q30));
                    U_QD2: q_reg[2] <= 32'(clamp(quotient, ONE_Q30));
                    U_QD3: q_reg[3] <= 32'(clamp(quotient, ONE_Q30));
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            ax_reg <= accel_x;
            ay_reg <= accel_y;
            az_reg <= accel_z;
            gx_reg <= rate_x;
            gy_reg <= rate_y;
            gz_reg <= rate_z;
            for (int i = 0; i < 4; i++)
                gn_reg[i] <= '0;
        end
        if (cmd.issue)
            prod_reg <= full[63:0];
        if (div_done)
        begin
            case (cmd.uop)
                U_DVX: nx_reg <= 32'(clamp(quotient, ONE_Q30));
                U_DVY: ny_reg <= 32'(clamp(quotient, ONE_Q30));
                U_DVZ: nz_reg <= 32'(clamp(quotient, ONE_Q30));
                U_GN0: gn_reg[0] <= 36'(quotient);
                U_GN1: gn_reg[1] <= 36'(quotient);
                U_GN2: gn_reg[2] <= 36'(quotient);
                U_GN3: gn_reg[3] <= 36'(quotient);
                default: ;
            endcase
        end
        if (cmd.write)
        begin
            case (cmd.uop)
                U_AXX: asum_reg <= prod_reg;
                U_AYY, U_AZZ: asum_reg <= asum_reg + prod_reg;
                U_F1A, U_F2A, U_F3A: t_reg <= prod_reg;
                U_F1B: f1_reg <= 36'(((t_reg - prod_reg) >>> 29) - 64'(nx_reg));
                U_F2B: f2_reg <= 36'(((t_reg + prod_reg) >>> 29) - 64'(ny_reg));
                U_F3B: f3_reg <= 36'(ONE_Q30 - ((t_reg + prod_reg) >>> 29) - 64'(nz_reg));
                U_G0A: acc_reg <= mq;
                U_G0B: g_reg[0] <= 36'((acc_reg - mq) >>> 7);
                U_G1A: acc_reg <= mq <<< 1;
                U_G1B: acc_reg <= acc_reg + (mq <<< 1);
                U_G1C: g_reg[1] <= 36'((acc_reg - (mq <<< 2)) >>> 8);
                U_G2A: acc_reg <= mq <<< 1;
                U_G2B: acc_reg <= acc_reg - (mq <<< 2);
                U_G2C: g_reg[2] <= 36'((acc_reg - (mq <<< 1)) >>> 8);
                U_G3A: acc_reg <= mq <<< 1;
                U_G3B: g_reg[3] <= 36'((acc_reg + (mq <<< 1)) >>> 8);
                U_GS0: gs_reg <= prod_reg;
                U_GS1, U_GS2, U_GS3: gs_reg <= gs_reg + prod_reg;
                U_R0A: acc_reg <= -prod_reg;
                U_R0B: acc_reg <= acc_reg - prod_reg;
                U_R0C: racc_reg <= (acc_reg - prod_reg) >>> 12;
                U_R1A: acc_reg <= prod_reg;
                U_R1B: acc_reg <= acc_reg + prod_reg;
                U_R1C: racc_reg <= (acc_reg - prod_reg) >>> 12;
                U_R2A: acc_reg <= prod_reg;
                U_R2B: acc_reg <= acc_reg - prod_reg;
                U_R2C: racc_reg <= (acc_reg + prod_reg) >>> 12;
                U_R3A: acc_reg <= prod_reg;
                U_R3B: acc_reg <= acc_reg + prod_reg;
                U_R3C: racc_reg <= (acc_reg - prod_reg) >>> 12;
                U_R0D, U_R1D, U_R2D, U_R3D: rr_reg <= 36'(racc_reg - (prod_reg >>> 14));
                U_R0E: nq_reg[0] <= 34'(clamp(64'(q_reg[0]) + (prod_reg >>> 24), QSAT));
                U_R1E: nq_reg[1] <= 34'(clamp(64'(q_reg[1]) + (prod_reg >>> 24), QSAT));
                U_R2E: nq_reg[2] <= 34'(clamp(64'(q_reg[2]) + (prod_reg >>> 24), QSAT));
                U_R3E: nq_reg[3] <= 34'(clamp(64'(q_reg[3]) + (prod_reg >>> 24), QSAT));
                U_QS0: qs_reg <= prod_reg;
                U_QS1, U_QS2, U_QS3: qs_reg <= qs_reg + prod_reg;
                default: ;
            endcase
        end
        if (cmd.load_out)
        begin
            for (int i = 0; i < 4; i++)
                qo_reg[i] <= q_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quat_valid_reg <= 1'b0;
        else if (cmd.load_out)
            quat_valid_reg <= 1'b1;
        else if (!quat_stall)
            quat_valid_reg <= 1'b0;
    end

    assign status.unit_done = sqrt_done || div_done;
    assign status.asum_zero = asum_reg == 64'd0;
    assign status.gs_zero = gs_reg == 64'd0;
    assign status.qs_zero = qs_reg == 64'd0;
    assign status.out_free = out_free;

    assign quat_valid = quat_valid_reg;
    assign quat_w = qo_reg[0];
    assign quat_x = qo_reg[1];
    assign quat_y = qo_reg[2];
    assign quat_z = qo_reg[3];
endmodule

/* rtl/imuqf_ctrl.sv */
module imuqf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  imuqf_pkg::status_t  status,
    output imuqf_pkg::cmd_t     cmd
);
    import imuqf_pkg::*;

    ctrl_state_t state_reg, state_next;
    uop_t pc_reg, pc_next;
    uop_t pc_inc;

    assign pc_inc = uop_t'(pc_reg + UOP_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg <= U_AXX;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg <= pc_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next = pc_reg;
        cmd = '0;
        cmd.uop = pc_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.accept = 1'b1;
                    pc_next = U_AXX;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (pc_reg == U_OUT)
                begin
                    if (status.out_free)
                    begin
                        cmd.load_out = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if ((pc_reg == U_ASQRT && status.asum_zero) ||
                         (pc_reg == U_GSQRT && status.gs_zero))
                    pc_next = U_R0A;
                else if (pc_reg == U_QSQRT && status.qs_zero)
                    pc_next = U_OUT;
                else if (uop_is_unit(pc_reg))
                begin
                    cmd.start = 1'b1;
                    state_next = S_WAIT;
                end
                else
                begin
                    cmd.issue = 1'b1;
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.write = 1'b1;
                pc_next = pc_inc;
                state_next = S_RUN;
            end
            S_WAIT:
            begin
                if (status.unit_done)
                begin
                    pc_next = pc_inc;
                    state_next = S_RUN;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign sample_stall = state_reg != S_IDLE;
endmodule
